### hw/rtl/bsc_pkg.sv
// shared types, constants and helpers for the barometric compensation pipeline
package bsc_pkg;

   localparam int unsigned DIV_W    = 33;   // dividend and quotient width
   localparam int unsigned DVS_W    = 32;   // divisor width
   localparam int unsigned SIDE_W   = 37;   // sideband carried through a divider
   localparam int unsigned CSR_AW   = 5;
   localparam int unsigned NUM_REGS = 5;

   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;

   localparam logic signed [63:0] B6_OFFSET   = 64'sd4000;
   localparam logic signed [63:0] P_SQ_COEF   = 64'sd3038;
   localparam logic signed [63:0] P_LIN_COEF  = -64'sd7357;
   localparam logic signed [63:0] P_OFFSET    = 64'sd3791;
   localparam logic [31:0]        B7_SCALE    = 32'd50000;
   localparam logic [31:0]        B4_OFFSET   = 32'd32768;
   localparam logic signed [63:0] T_MAX       = 64'sd32767;
   localparam logic signed [63:0] T_MIN       = -64'sd32768;
   localparam logic signed [63:0] P_MAX       = 64'sd262143;

   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic        [15:0] ac4;
      logic        [15:0] ac5;
      logic        [15:0] ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
   } cal_type;

   typedef struct packed {
      logic [DVS_W-1:0]  rem;
      logic [DIV_W-1:0]  dq;
      logic [DVS_W-1:0]  dvs;
      logic [SIDE_W-1:0] side;
   } div_stage_type;

   // sideband through the temperature divider
   typedef struct packed {
      logic signed [18:0] x1;
      logic [15:0]        up;
      logic               neg;
      logic               fault;
   } side_t_type;

   // sideband through the pressure divider
   typedef struct packed {
      logic [18:0]        pad;
      logic signed [15:0] t;
      logic               fault;
      logic               branch;
   } side_p_type;

   // signed divide by 2^k truncating toward zero
   function automatic logic signed [63:0] tdiv_p2(input logic signed [63:0] x,
                                                  input logic [5:0] k);
      logic signed [63:0] bias;
      bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (x + bias) >>> k;
   endfunction

endpackage

### hw/rtl/bsc_csr.sv
// calibration register file behind the apb-style port
module bsc_csr import bsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cal_type           cal
);

   logic [31:0] regs_ff [NUM_REGS];
   logic [2:0]  idx;
   logic        wr;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else if (wr) begin
         unique case (idx)
            REG_AC1_AC2: regs_ff[0] <= csr_pwdata;
            REG_AC3_AC4: regs_ff[1] <= csr_pwdata;
            REG_AC5_AC6: regs_ff[2] <= csr_pwdata;
            REG_B1_B2:   regs_ff[3] <= csr_pwdata;
            REG_MC_MD:   regs_ff[4] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_AC1_AC2: csr_prdata = regs_ff[0];
         REG_AC3_AC4: csr_prdata = regs_ff[1];
         REG_AC5_AC6: csr_prdata = regs_ff[2];
         REG_B1_B2:   csr_prdata = regs_ff[3];
         REG_MC_MD:   csr_prdata = regs_ff[4];
         default:     csr_prdata = '0;
      endcase
   end

   assign cal.ac1 = regs_ff[0][31:16];
   assign cal.ac2 = regs_ff[0][15:0];
   assign cal.ac3 = regs_ff[1][31:16];
   assign cal.ac4 = regs_ff[1][15:0];
   assign cal.ac5 = regs_ff[2][31:16];
   assign cal.ac6 = regs_ff[2][15:0];
   assign cal.b1  = regs_ff[3][31:16];
   assign cal.b2  = regs_ff[3][15:0];
   assign cal.mc  = regs_ff[4][31:16];
   assign cal.md  = regs_ff[4][15:0];

endmodule

### hw/rtl/bsc_div.sv
// pipelined restoring unsigned divider, one quotient bit per stage
module bsc_div import bsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  in_dividend,
   input  logic [DVS_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DIV_W-1:0]  out_quotient,
   output logic [SIDE_W-1:0] out_side
);

   logic [DIV_W:0] v_ff;
   div_stage_type  st_ff [DIV_W+1];
   div_stage_type  st_in [DIV_W];

   for (genvar k = 0; k < DIV_W; k++) begin : g_step
      logic [DVS_W:0] trial;
      logic [DVS_W:0] diff;
      always_comb begin
         trial = {st_ff[k].rem, st_ff[k].dq[DIV_W-1]};
         diff  = trial - {1'b0, st_ff[k].dvs};
         st_in[k] = st_ff[k];
         if (trial >= {1'b0, st_ff[k].dvs}) begin
            st_in[k].rem = diff[DVS_W-1:0];
            st_in[k].dq  = {st_ff[k].dq[DIV_W-2:0], 1'b1};
         end else begin
            st_in[k].rem = trial[DVS_W-1:0];
            st_in[k].dq  = {st_ff[k].dq[DIV_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) st_ff[k+1] <= st_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) st_ff[0] <= '{rem: '0, dq: in_dividend, dvs: in_divisor, side: in_side};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[DIV_W-1:0], in_valid};
      end
   end

   assign out_valid    = v_ff[DIV_W];
   assign out_quotient = st_ff[DIV_W].dq;
   assign out_side     = st_ff[DIV_W].side;

   chk_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("divider valid moved during stall");
   chk_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !out_valid)
      else $error("divider output valid right after reset");
   chk_pass_through: assert property (@(posedge clock) disable iff (reset)
      (adv && in_valid) |=> v_ff[0])
      else $error("divider lost an entering beat");

endmodule

### hw/rtl/barometric_sensor_compensation.sv
// top level: stream in raw words, pipeline the integer compensation, stream out results
//
// Fully pipelined: a new raw pair can be taken every cycle unless the result side stalls,
// and each result passes through 82 registers (2 front stages, a 34-stage temperature
// divider, 9 middle stages, a 34-stage pressure divider, 2 back stages and the output
// register), the first of which loads at the accepting edge.
// The two dividers are restoring units producing one quotient bit per stage and set the
// latency. A stall on the result side freezes the whole pipe, so req_tready follows
// rsp_tready whenever a result is waiting. Calibration is written through the csr port
// and must only change while the pipe is empty. A zero divisor raises divide_fault with
// both values zero.
module barometric_sensor_compensation import bsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // raw_temperature[15:0], raw_pressure[31:16]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // temperature_tenths[15:0], pressure_pascal[33:16],
                                          // divide_fault[34], zero[39:35]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cal_type cal;
   logic    adv;

   bsc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cal
   );

   logic rsp_tvalid_ff;
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // front stages
   logic               f1_v_ff, f2_v_ff;
   logic signed [17:0] f1_d_ff;
   logic [15:0]        f1_up_ff, f2_up_ff;
   logic signed [34:0] f2_prod_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_d_ff    <= $signed({2'b0, req_tdata[15:0]}) - $signed({2'b0, cal.ac6});
         f1_up_ff   <= req_tdata[31:16];
         f2_prod_ff <= 35'(f1_d_ff * $signed({1'b0, cal.ac5}));
         f2_up_ff   <= f1_up_ff;
      end
   end

   logic signed [63:0] x1_w;
   logic signed [18:0] x1_t;
   logic signed [19:0] den;
   logic signed [26:0] num;
   logic [26:0]        num_mag;
   logic [19:0]        den_mag;
   side_t_type         s1_in, s1_out;
   logic               d1_v;
   logic [DIV_W-1:0]   q1;
   logic [SIDE_W-1:0]  s1_out_raw;

   always_comb begin
      x1_w    = tdiv_p2(64'(f2_prod_ff), 6'd15);
      x1_t    = x1_w[18:0];
      den     = 20'(x1_t) + 20'(cal.md);
      num     = {cal.mc, 11'b0};
      num_mag = num[26] ? 27'(-num) : 27'(num);
      den_mag = den[19] ? 20'(-den) : 20'(den);
      s1_in   = '{x1: x1_t, up: f2_up_ff, neg: num[26] ^ den[19], fault: den == '0};
   end

   bsc_div u_div_t (
      .clock, .reset, .adv, .in_valid(f2_v_ff),
      .in_dividend({6'b0, num_mag}), .in_divisor({12'b0, den_mag}),
      .in_side(SIDE_W'(s1_in)),
      .out_valid(d1_v), .out_quotient(q1), .out_side(s1_out_raw)
   );
   assign s1_out = side_t_type'(s1_out_raw);

   // middle stages
   logic [8:0]         m_v_ff;
   logic [15:0]        m1_up_ff, m2_up_ff, m3_up_ff, m4_up_ff, m5_up_ff, m6_up_ff,
                       m7_up_ff;
   logic [8:0]         m_f_ff;
   logic signed [15:0] m2_t_ff, m3_t_ff, m4_t_ff, m5_t_ff, m6_t_ff, m7_t_ff, m8_t_ff,
                       m9_t_ff;
   logic signed [27:0] m1_b5_ff, m2_b6_ff;
   logic signed [55:0] m3_sq_ff;
   logic signed [43:0] m3_pa2_ff, m3_pa3_ff, m4_sq4_ff;
   logic signed [32:0] m4_x2a_ff, m5_x2a_ff;
   logic signed [30:0] m4_x1c_ff, m5_x1c_ff;
   logic signed [59:0] m5_pb2_ff, m5_pb1_ff;
   logic signed [50:0] m6_x3_ff;
   logic signed [45:0] m6_s2_ff;
   logic [31:0]        m7_b3_ff, m7_xs_ff, m8_diff_ff, m9_b7_ff;
   logic [16:0]        m8_b4_ff, m9_b4_ff;

   logic signed [27:0] x2_t;
   logic signed [63:0] t_w, t_c;
   logic signed [63:0] x3_w, s2_w, b3_w, xs_w;
   logic [31:0]        b4_prod;

   always_comb begin
      x2_t = s1_out.neg ? -$signed({1'b0, q1[26:0]}) : $signed({1'b0, q1[26:0]});
      t_w  = tdiv_p2(64'(m1_b5_ff) + 64'sd8, 6'd4);
      if (t_w > T_MAX)      t_c = T_MAX;
      else if (t_w < T_MIN) t_c = T_MIN;
      else                  t_c = t_w;
      x3_w = tdiv_p2(64'(m5_pb2_ff), 6'd11) + 64'(m5_x2a_ff);
      s2_w = 64'(m5_x1c_ff) + tdiv_p2(64'(m5_pb1_ff), 6'd16) + 64'sd2;
      b3_w = tdiv_p2(64'(cal.ac1) * 64'sd4 + 64'(m6_x3_ff) + 64'sd2, 6'd2);
      xs_w = (64'(m6_s2_ff) >>> 2) + 64'(B4_OFFSET);
      b4_prod = 32'({16'b0, cal.ac4} * m7_xs_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_b5_ff  <= 28'(s1_out.x1) + x2_t;
         m1_up_ff  <= s1_out.up;
         m2_b6_ff  <= m1_b5_ff - 28'(B6_OFFSET);
         m2_t_ff   <= t_c[15:0];
         m2_up_ff  <= m1_up_ff;
         m3_sq_ff  <= 56'(m2_b6_ff * m2_b6_ff);
         m3_pa2_ff <= 44'(cal.ac2 * m2_b6_ff);
         m3_pa3_ff <= 44'(cal.ac3 * m2_b6_ff);
         m3_t_ff   <= m2_t_ff;
         m3_up_ff  <= m2_up_ff;
         m4_sq4_ff <= 44'(m3_sq_ff >>> 12);
         m4_x2a_ff <= 33'(m3_pa2_ff >>> 11);
         m4_x1c_ff <= 31'(tdiv_p2(64'(m3_pa3_ff), 6'd13));
         m4_t_ff   <= m3_t_ff;
         m4_up_ff  <= m3_up_ff;
         m5_pb2_ff <= 60'(cal.b2 * m4_sq4_ff);
         m5_pb1_ff <= 60'(cal.b1 * m4_sq4_ff);
         m5_x2a_ff <= m4_x2a_ff;
         m5_x1c_ff <= m4_x1c_ff;
         m5_t_ff   <= m4_t_ff;
         m5_up_ff  <= m4_up_ff;
         m6_x3_ff  <= x3_w[50:0];
         m6_s2_ff  <= s2_w[45:0];
         m6_t_ff   <= m5_t_ff;
         m6_up_ff  <= m5_up_ff;
         m7_b3_ff  <= b3_w[31:0];
         m7_xs_ff  <= xs_w[31:0];
         m7_t_ff   <= m6_t_ff;
         m7_up_ff  <= m6_up_ff;
         m8_b4_ff  <= b4_prod[31:15];
         m8_diff_ff <= {16'b0, m7_up_ff} - m7_b3_ff;
         m8_t_ff   <= m7_t_ff;
         m9_b7_ff  <= 32'(m8_diff_ff * B7_SCALE);
         m9_b4_ff  <= m8_b4_ff;
         m9_t_ff   <= m8_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         m_v_ff  <= '0;
      end else if (adv) begin
         f1_v_ff <= req_tvalid;
         f2_v_ff <= f1_v_ff;
         m_v_ff  <= {m_v_ff[7:0], d1_v};
      end
   end

   // fault flags ride beside the data; the b4 check joins at the last middle stage
   always_ff @(posedge clock) begin
      if (adv) begin
         m_f_ff[7:0] <= {m_f_ff[6:0], s1_out.fault};
         m_f_ff[8]   <= m_f_ff[7] | (m8_b4_ff == '0);
      end
   end

   side_p_type        s2_in, s2_out;
   logic              d2_v;
   logic [DIV_W-1:0]  q2, dvd2;
   logic [SIDE_W-1:0] s2_out_raw;

   always_comb begin
      s2_in = '{pad: '0, t: m9_t_ff, fault: m_f_ff[8], branch: m9_b7_ff[31]};
      dvd2  = m9_b7_ff[31] ? {1'b0, m9_b7_ff} : {m9_b7_ff, 1'b0};
   end

   bsc_div u_div_p (
      .clock, .reset, .adv, .in_valid(m_v_ff[8]),
      .in_dividend(dvd2), .in_divisor({15'b0, m9_b4_ff}),
      .in_side(SIDE_W'(s2_in)),
      .out_valid(d2_v), .out_quotient(q2), .out_side(s2_out_raw)
   );
   assign s2_out = side_p_type'(s2_out_raw);

   // back stages
   logic               b1_v_ff, b2_v_ff;
   logic [33:0]        p_w, b1_p_ff, b2_p_ff;
   logic [51:0]        b1_sq_ff;
   logic signed [48:0] b1_pm_ff;
   logic signed [63:0] b2_x1_ff, b2_x2_ff;
   logic signed [15:0] b1_t_ff, b2_t_ff;
   logic               b1_f_ff, b2_f_ff;
   logic signed [63:0] pn_w, pc_w;

   always_comb begin
      p_w  = s2_out.branch ? {q2, 1'b0} : {1'b0, q2};
      pn_w = 64'(b2_p_ff) + tdiv_p2(b2_x1_ff + b2_x2_ff + P_OFFSET, 6'd4);
      if (pn_w < 64'sd0)      pc_w = 64'sd0;
      else if (pn_w > P_MAX)  pc_w = P_MAX;
      else                    pc_w = pn_w;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_p_ff  <= p_w;
         b1_sq_ff <= 52'(p_w[33:8] * p_w[33:8]);
         b1_pm_ff <= 49'(P_LIN_COEF * $signed({30'b0, p_w}));
         b1_t_ff  <= s2_out.t;
         b1_f_ff  <= s2_out.fault;
         b2_x1_ff <= tdiv_p2($signed({12'b0, b1_sq_ff}) * P_SQ_COEF, 6'd16);
         b2_x2_ff <= tdiv_p2(64'(b1_pm_ff), 6'd16);
         b2_p_ff  <= b1_p_ff;
         b2_t_ff  <= b1_t_ff;
         b2_f_ff  <= b1_f_ff;
      end
   end

   logic [39:0] rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= b2_f_ff ? {5'b0, 1'b1, 34'b0}
                                 : {5'b0, 1'b0, pc_w[17:0], b2_t_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff       <= 1'b0;
         b2_v_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         b1_v_ff       <= d2_v;
         b2_v_ff       <= b1_v_ff;
         rsp_tvalid_ff <= b2_v_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   chk_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[34]) |-> (rsp_tdata_ff[33:0] == '0))
      else $error("fault result carries nonzero values");
   chk_stall_front: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> ($stable(f1_v_ff) && $stable(m_v_ff)))
      else $error("pipeline moved while output stalled");
   chk_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid_ff)
      else $error("result valid right after reset");

endmodule

### test/barometric_sensor_compensation_tb.sv
// self-checking testbench for the barometric compensation pipeline
module barometric_sensor_compensation_tb import bsc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] temp;
      logic [17:0]        press;
      logic               fault;
   } reading_type;

   typedef struct {
      logic [15:0] ut;
      logic [15:0] up;
      logic        fixed;
      reading_type want;
   } row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;   // raw_temperature[15:0], raw_pressure[31:16]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;        // temperature[15:0], pressure[33:16], fault[34]
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   logic [31:0]  cal_regs [NUM_REGS];
   reading_type  pending_readings [$];
   int           mismatches = 0;
   int           beats_sent = 0;
   int           sink_idle_pct = 30;
   int           source_idle_pct = 30;
   int           hold_left = 0;
   bit           held = 1'b0;

   barometric_sensor_compensation u_dut (.*);

   always #5 clock = ~clock;

   function automatic reading_type compensate(input logic [15:0] ut_w, input logic [15:0] up_w);
      longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
      longint x1, x2, x3, den, b5, b6, b3, t, p;
      logic [31:0] ac4w, x3w, b4, b7;
      logic [63:0] wide;
      reading_type r;
      ac1 = longint'($signed(cal_regs[REG_AC1_AC2][31:16]));
      ac2 = longint'($signed(cal_regs[REG_AC1_AC2][15:0]));
      ac3 = longint'($signed(cal_regs[REG_AC3_AC4][31:16]));
      ac4w = {16'd0, cal_regs[REG_AC3_AC4][15:0]};
      ac5 = longint'({48'd0, cal_regs[REG_AC5_AC6][31:16]});
      ac6 = longint'({48'd0, cal_regs[REG_AC5_AC6][15:0]});
      b1 = longint'($signed(cal_regs[REG_B1_B2][31:16]));
      b2 = longint'($signed(cal_regs[REG_B1_B2][15:0]));
      mc = longint'($signed(cal_regs[REG_MC_MD][31:16]));
      md = longint'($signed(cal_regs[REG_MC_MD][15:0]));
      ut = longint'({48'd0, ut_w});
      r = '{temp: '0, press: '0, fault: 1'b1};
      x1 = ((ut - ac6) * ac5) / 32768;
      den = x1 + md;
      if (den == 0) return r;
      x2 = (mc * 2048) / den;
      b5 = x1 + x2;
      t = (b5 + 8) / 16;
      b6 = b5 - 4000;
      x1 = (b2 * ((b6 * b6) / 4096)) / 2048;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = (ac1 * 4 + x3 + 2) / 4;
      x1 = (ac3 * b6) / 8192;
      x2 = (b1 * ((b6 * b6) / 4096)) / 65536;
      x3 = (x1 + x2 + 2) >>> 2;
      x3w = 32'(x3 + 32768);
      b4 = (ac4w * x3w) >> 15;
      if (b4 == 0) return r;
      b7 = ({16'd0, up_w} - b3[31:0]) * 32'd50000;
      // quotient kept unsigned; top branch avoids overflow of the doubled dividend
      if (b7 < 32'h8000_0000) begin
         wide = ({32'd0, b7} * 64'd2) / {32'd0, b4};
         p = longint'(wide);
      end else begin
         p = longint'({32'd0, b7 / b4}) * 2;
      end
      x1 = (p / 256) * (p / 256);
      x1 = (x1 * 3038) / 65536;
      x2 = (-64'sd7357 * p) / 65536;
      p = p + (x1 + x2 + 3791) / 16;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (p < 0) p = 0;
      if (p > 262143) p = 262143;
      r.temp = t[15:0];
      r.press = p[17:0];
      r.fault = 1'b0;
      return r;
   endfunction

   function automatic int gap_cycles(input int idle_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll >= idle_pct) return 0;
      if (roll < idle_pct * 8 / 10) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic write_cal(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx < NUM_REGS) cal_regs[idx] = value;
   endtask

   task automatic load_cal(input logic [31:0] r0, r1, r2, r3, r4);
      write_cal(REG_AC1_AC2, r0);
      write_cal(REG_AC3_AC4, r1);
      write_cal(REG_AC5_AC6, r2);
      write_cal(REG_B1_B2, r3);
      write_cal(REG_MC_MD, r4);
   endtask

   // pipe must be empty before calibration changes
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send(input logic [15:0] ut, input logic [15:0] up, input bit fixed,
                       input reading_type want);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {up, ut};
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(fixed ? want : compensate(ut, up));
      beats_sent++;
      gap = gap_cycles(source_idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (beats_sent >= 200 && !held) begin
         held = 1'b1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", rsp_tdata);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[15:0] !== want.temp || rsp_tdata[33:16] !== want.press ||
                rsp_tdata[34] !== want.fault || rsp_tdata[39:35] !== 5'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected t=%0d p=%0d f=%0d, got t=%0d p=%0d f=%0d pad=%h",
                           want.temp, want.press, want.fault, $signed(rsp_tdata[15:0]),
                           rsp_tdata[33:16], rsp_tdata[34], rsp_tdata[39:35]);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      row_type table_a [] = '{
         '{16'h0000, 16'h0000, 1'b1, '{temp: 16'sd0, press: 18'd0, fault: 1'b1}},
         '{16'hffff, 16'hffff, 1'b1, '{temp: 16'sd0, press: 18'd0, fault: 1'b1}},
         '{16'h5555, 16'haaaa, 1'b1, '{temp: 16'sd0, press: 18'd0, fault: 1'b1}}};
      row_type table_b [] = '{
         '{16'd27898, 16'd23843, 1'b0, '{temp: '0, press: '0, fault: 1'b0}},
         '{16'h0000, 16'h0000, 1'b0, '{temp: '0, press: '0, fault: 1'b0}},
         '{16'hffff, 16'hffff, 1'b0, '{temp: '0, press: '0, fault: 1'b0}},
         '{16'h0000, 16'hffff, 1'b0, '{temp: '0, press: '0, fault: 1'b0}},
         '{16'hffff, 16'h0000, 1'b0, '{temp: '0, press: '0, fault: 1'b0}},
         '{16'h8000, 16'h7fff, 1'b0, '{temp: '0, press: '0, fault: 1'b0}},
         '{16'd23153, 16'd30000, 1'b0, '{temp: '0, press: '0, fault: 1'b0}}};
      logic [31:0] pick [5];
      reading_type none;
      none = '0;
      for (int i = 0; i < NUM_REGS; i++) cal_regs[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: md is zero so the temperature divisor is zero
      foreach (table_a[i]) send(table_a[i].ut, table_a[i].up, table_a[i].fixed, table_a[i].want);
      drain();
      // typical datasheet calibration
      load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
               {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
      write_cal(3'(NUM_REGS), 32'hdead_beef);   // unused index, ignored
      foreach (table_b[i]) send(table_b[i].ut, table_b[i].up, table_b[i].fixed, table_b[i].want);
      drain();
      // ac4 of zero leaves the pressure divisor at zero
      write_cal(REG_AC3_AC4, {-16'sd14383, 16'd0});
      send(16'd27898, 16'd23843, 1'b1, '{temp: 16'sd0, press: 18'd0, fault: 1'b1});
      drain();
      // temperature clamps: tiny divisor, huge mc
      load_cal(32'h7fff_8000, 32'h7fff_ffff, {16'hffff, 16'd0}, 32'h8000_7fff, {16'sd32767, 16'sd1});
      send(16'd0, 16'd100, 1'b0, none);
      drain();
      write_cal(REG_MC_MD, {-16'sd32768, 16'sd1});
      send(16'd0, 16'hffff, 1'b0, none);
      drain();
      load_cal(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send(16'hffff, 16'hffff, 1'b0, none);
      send(16'h0000, 16'h0000, 1'b0, none);
      send(16'h1234, 16'hfedc, 1'b0, none);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 2 == 0) begin
            // near-typical calibration keeps results in range
            pick[0] = {16'($urandom_range(0, 2000) - 1000 + 408),
                       16'($urandom_range(0, 400) - 200 - 72)};
            pick[1] = {16'($urandom_range(0, 4000) - 2000 - 14383),
                       16'($urandom_range(20000, 40000))};
            pick[2] = {16'($urandom_range(20000, 40000)), 16'($urandom_range(15000, 30000))};
            pick[3] = {16'($urandom_range(4000, 8000)), 16'($urandom_range(0, 50))};
            pick[4] = {16'($urandom_range(0, 4000) - 2000 - 8711),
                       16'($urandom_range(2000, 4000))};
         end else begin
            for (int i = 0; i < NUM_REGS; i++) pick[i] = $urandom();
         end
         load_cal(pick[0], pick[1], pick[2], pick[3], pick[4]);
         source_idle_pct = (phase % 3 == 0) ? 0 : 30;
         sink_idle_pct = (phase % 4 == 1) ? 0 : 30;
         for (int n = 0; n < 55; n++) begin
            if (phase % 2 == 0 && $urandom_range(0, 3) != 0)
               send(16'($urandom_range(20000, 36000)), 16'($urandom_range(15000, 45000)),
                    1'b0, none);
            else
               send(16'($urandom()), 16'($urandom()), 1'b0, none);
         end
         drain();
      end

      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
